[rtl/psa_pkg.sv]
// ----------------------------------------------------------------------------
// psa_pkg
// shared types and constants of the pixel saturation adjust core
// ----------------------------------------------------------------------------
package psa_pkg;

    // default channel width and strength fraction width
    localparam int CHAN_BITS_DEF       = 24;
    localparam int SCALE_FRAC_BITS_DEF = 12;

    // configuration port
    localparam int CFG_BITS = 16;
    localparam int IDX_BITS = 3;

    // fixed chroma origins of cie yuv, 4/19 and 9/19 in q8.15
    localparam int U_ORIGIN = 6899;
    localparam int V_ORIGIN = 15522;

    // register reset values
    localparam logic [15:0] STRENGTH_RST = 16'd4096;
    localparam logic [15:0] WRED_RST     = 16'd13933;
    localparam logic [15:0] WGREEN_RST   = 16'd46871;
    localparam logic [15:0] WBLUE_RST    = 16'd4732;

    typedef enum logic [1:0] {
        MODE_RGB = 2'd0,
        MODE_LAB = 2'd1,
        MODE_LCH = 2'd2,
        MODE_YUV = 2'd3
    } t_mode;

    typedef enum logic [IDX_BITS-1:0] {
        REG_MODE     = 3'd0,
        REG_STRENGTH = 3'd1,
        REG_WRED     = 3'd2,
        REG_WGREEN   = 3'd3,
        REG_WBLUE    = 3'd4
    } t_reg_idx;

endpackage

[rtl/pixel_saturation_adjust_core.sv]
// ----------------------------------------------------------------------------
// pixel_saturation_adjust_core
// scales the saturation of a pixel stream in rgb, lab, lch or cie yuv
// ----------------------------------------------------------------------------
// usage
//   slave stream i_s_axis_*: one pixel per transaction, tdata holds chan_a,
//   chan_b, chan_c and opacity, tlast marks the last pixel of a buffer
//   master stream o_m_axis_*: one adjusted pixel per accepted pixel, same
//   packing, opacity and tlast copied through
//   config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (mode, strength, weight_red, weight_green, weight_blue); write only
//   while the pipeline is empty, unknown indexes are dropped
// timing
//   eight register stages, latency 7 cycles from accept to o_m_axis_tvalid
//   one pixel per cycle sustained; the figure is set by the per-stage
//   handshake, each stage takes a new pixel whenever it empties or hands on
//   its own, and the slowest stage holds one multiplier pass
// reset and stall
//   i_rst_n low clears all stage valid bits and restores register defaults
//   when the receiver stalls, the result holds in the last stage and the
//   stages behind it keep filling until the pipe is full, then
//   o_s_axis_tready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module pixel_saturation_adjust_core #(
    parameter int CHAN_BITS       = psa_pkg::CHAN_BITS_DEF,
    parameter int SCALE_FRAC_BITS = psa_pkg::SCALE_FRAC_BITS_DEF,
    parameter int DATA_BITS       = ((3 * CHAN_BITS + 16 + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata from bit 0: chan_a, chan_b, chan_c, opacity, zero pad
    input  logic [DATA_BITS-1:0]          i_s_axis_tdata,
    input  logic                          i_s_axis_tlast,
    // master stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata from bit 0: out_a, out_b, out_c, out_opacity, zero pad
    output logic [DATA_BITS-1:0]          o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [psa_pkg::IDX_BITS-1:0]  i_cfg_idx,
    input  logic [psa_pkg::CFG_BITS-1:0]  i_cfg_data
);
    import psa_pkg::*;

    localparam int CB    = CHAN_BITS;
    localparam int F     = SCALE_FRAC_BITS;
    localparam int NSTG  = 8;
    localparam int XW    = CB + 1;      // channel minus origin
    localparam int PW    = CB + 17;     // channel times weight
    localparam int QW    = CB + 18;     // channel times strength
    localparam int SW    = CB + 19;     // weighted sum
    localparam int LW    = CB + 3;      // luma
    localparam int BW    = CB + 21;     // luma times (1 - strength)
    localparam int TW    = CB + 22;     // blended value before rounding
    localparam int RW    = TW - F;      // rounded value
    localparam int YW    = RW + 1;      // after origin add
    localparam int PAYW  = 3 * CB + 16;
    localparam int ONE   = 1 << F;

    localparam logic signed [YW-1:0] Y_MAX = YW'((64'd1 << (CB - 1)) - 64'd1);
    localparam logic signed [YW-1:0] Y_MIN = -Y_MAX - YW'(1);
    localparam logic signed [XW-1:0] U_ORG_X = XW'(U_ORIGIN);
    localparam logic signed [XW-1:0] V_ORG_X = XW'(V_ORIGIN);
    localparam logic signed [YW-1:0] U_ORG_Y = YW'(U_ORIGIN);
    localparam logic signed [YW-1:0] V_ORG_Y = YW'(V_ORIGIN);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    t_mode       r_mode;
    logic [15:0] r_strength;
    logic [15:0] r_wred;
    logic [15:0] r_wgreen;
    logic [15:0] r_wblue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_RGB;
            r_strength <= STRENGTH_RST;
            r_wred     <= WRED_RST;
            r_wgreen   <= WGREEN_RST;
            r_wblue    <= WBLUE_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MODE:     r_mode     <= t_mode'(i_cfg_data[1:0]);
                REG_STRENGTH: r_strength <= i_cfg_data[15:0];
                REG_WRED:     r_wred     <= i_cfg_data[15:0];
                REG_WGREEN:   r_wgreen   <= i_cfg_data[15:0];
                REG_WBLUE:    r_wblue    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic signed [16:0] w_k;
    logic signed [17:0] w_rk;
    assign w_k  = $signed({1'b0, r_strength});
    assign w_rk = $signed(18'(ONE)) - $signed({2'b00, r_strength});

    // ------------------------------------------------------------------
    // stage handshake: a stage loads when empty or when its successor loads
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   w_rdy;
    logic [NSTG-1:0] w_en;
    logic [NSTG-1:0] w_vin;

    always_comb begin
        w_rdy[NSTG] = i_m_axis_tready;
        for (int s = NSTG - 1; s >= 0; s--) begin
            w_rdy[s] = !r_v[s] || w_rdy[s+1];
            w_en[s]  = w_rdy[s];
            w_vin[s] = (s == 0) ? i_s_axis_tvalid : r_v[(s == 0) ? 0 : s - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < NSTG; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= w_vin[s];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // side line: original channels, opacity and last ride along
    // ------------------------------------------------------------------
    logic signed [CB-1:0] r_ch [NSTG][3];
    logic [15:0]          r_op [NSTG];
    logic                 r_last [NSTG];

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NSTG; s++) begin
            if (w_en[s]) begin
                if (s == 0) begin
                    for (int c = 0; c < 3; c++) begin
                        r_ch[0][c] <= $signed(i_s_axis_tdata[c*CB +: CB]);
                    end
                    r_op[0]   <= i_s_axis_tdata[3*CB +: 16];
                    r_last[0] <= i_s_axis_tlast;
                end else begin
                    r_ch[s]   <= r_ch[(s == 0) ? 0 : s - 1];
                    r_op[s]   <= r_op[(s == 0) ? 0 : s - 1];
                    r_last[s] <= r_last[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: chroma differences about the yuv origins
    // ------------------------------------------------------------------
    logic signed [XW-1:0] r_du0;
    logic signed [XW-1:0] r_dv0;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_du0 <= XW'($signed(i_s_axis_tdata[CB +: CB])) - U_ORG_X;
            r_dv0 <= XW'($signed(i_s_axis_tdata[2*CB +: CB])) - V_ORG_X;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: luma weight products and strength products
    // ------------------------------------------------------------------
    logic signed [XW-1:0] w_x1 [3];
    logic signed [PW-1:0] r_p1 [3];
    logic signed [QW-1:0] r_q1 [3];

    always_comb begin
        w_x1[0] = XW'(r_ch[0][0]);
        w_x1[1] = (r_mode == MODE_YUV) ? r_du0 : XW'(r_ch[0][1]);
        w_x1[2] = (r_mode == MODE_YUV) ? r_dv0 : XW'(r_ch[0][2]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_p1[0] <= r_ch[0][0] * $signed({1'b0, r_wred});
            r_p1[1] <= r_ch[0][1] * $signed({1'b0, r_wgreen});
            r_p1[2] <= r_ch[0][2] * $signed({1'b0, r_wblue});
            for (int c = 0; c < 3; c++) begin
                r_q1[c] <= w_x1[c] * w_k;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: weighted sum
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_sum2;
    logic signed [QW-1:0] r_q2 [3];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_sum2 <= SW'(r_p1[0]) + SW'(r_p1[1]) + SW'(r_p1[2]);
            r_q2   <= r_q1;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: luma, rounded half away from zero by 16 bits
    // ------------------------------------------------------------------
    logic signed [SW-1:0] w_sum_rnd;
    logic signed [LW-1:0] r_luma3;
    logic signed [QW-1:0] r_q3 [3];

    assign w_sum_rnd = r_sum2 + SW'(1 << 15) - SW'(r_sum2[SW-1]);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_luma3 <= w_sum_rnd[SW-1:16];
            r_q3    <= r_q2;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: luma times (1 - strength)
    // ------------------------------------------------------------------
    logic signed [BW-1:0] r_base4;
    logic signed [QW-1:0] r_q4 [3];

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_base4 <= r_luma3 * w_rk;
            r_q4    <= r_q3;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: blend, luma term only in rgb mode
    // ------------------------------------------------------------------
    logic signed [TW-1:0] r_t5 [3];

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int c = 0; c < 3; c++) begin
                if (r_mode == MODE_RGB) begin
                    r_t5[c] <= TW'(r_base4) + TW'(r_q4[c]);
                end else begin
                    r_t5[c] <= TW'(r_q4[c]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 6: drop the strength fraction, rounded half away from zero
    // ------------------------------------------------------------------
    logic signed [TW-1:0] w_t_rnd [3];
    logic signed [RW-1:0] r_r6 [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_t_rnd[c] = r_t5[c] + TW'(1 << (F - 1)) - TW'(r_t5[c][TW-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int c = 0; c < 3; c++) begin
                r_r6[c] <= w_t_rnd[c][TW-1:F];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 7: origin add, saturation, pass-through select
    // ------------------------------------------------------------------
    logic signed [YW-1:0] w_y7 [3];
    logic [2:0]           w_sel7;
    logic signed [CB-1:0] r_out7 [3];

    always_comb begin
        w_sel7[0] = (r_mode == MODE_RGB);
        w_sel7[1] = 1'b1;
        w_sel7[2] = (r_mode != MODE_LCH);
        w_y7[0]   = YW'(r_r6[0]);
        w_y7[1]   = YW'(r_r6[1]) + ((r_mode == MODE_YUV) ? U_ORG_Y : YW'(0));
        w_y7[2]   = YW'(r_r6[2]) + ((r_mode == MODE_YUV) ? V_ORG_Y : YW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            for (int c = 0; c < 3; c++) begin
                if (!w_sel7[c]) begin
                    r_out7[c] <= r_ch[6][c];
                end else if (w_y7[c] > Y_MAX) begin
                    r_out7[c] <= Y_MAX[CB-1:0];
                end else if (w_y7[c] < Y_MIN) begin
                    r_out7[c] <= Y_MIN[CB-1:0];
                end else begin
                    r_out7[c] <= w_y7[c][CB-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_v[NSTG-1];
    assign o_m_axis_tlast  = r_last[NSTG-1];

    always_comb begin
        o_m_axis_tdata = '0;
        for (int c = 0; c < 3; c++) begin
            o_m_axis_tdata[c*CB +: CB] = r_out7[c];
        end
        o_m_axis_tdata[PAYW-16 +: 16] = r_op[NSTG-1];
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an empty output stage opens the whole pipe to new pixels
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NSTG-1] |-> o_s_axis_tready)
        else $error("input stalled with an empty output stage");

    // a stalled result is never dropped from the output stage
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG-1] && !i_m_axis_tready) |=> r_v[NSTG-1])
        else $error("stalled result lost");

    // an idle input cycle leaves a bubble in the first stage
    a_bubble_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_axis_tready && !i_s_axis_tvalid) |=> !r_v[0])
        else $error("first stage valid without an input transaction");

    // a full pipe with a stalled receiver refuses new pixels
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("pixel accepted into a full stalled pipe");

endmodule
